[hdl/lfdlc_pkg.sv]
// Shared types, constants and register codes for the line-follow drive and lap counter.
package lfdlc_pkg;

   localparam int SENSOR_COUNT = 5;
   localparam int LAP_WIDTH = 16;

   localparam int SENSOR_WIDTH = 10;
   localparam int POS_WIDTH = 12;
   localparam int DRIVE_WIDTH = 12;
   localparam int LAP_TOTAL_WIDTH = 16;
   localparam int THRESH_WIDTH = 11;
   localparam int TOL_WIDTH = 10;
   localparam int GAIN_WIDTH = 10;

   localparam int REQ_FIELD_BITS = SENSOR_COUNT * SENSOR_WIDTH + POS_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * DRIVE_WIDTH + 2 + LAP_TOTAL_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 11;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MID_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DARK_MARGIN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIGHT_MARGIN = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REVERSE_SPEED = 3'd4;

   localparam logic [THRESH_WIDTH-1:0] UPPER_RESET = 11'd870;
   localparam logic [THRESH_WIDTH-1:0] MIDDLE_RESET = 11'd410;
   localparam logic [TOL_WIDTH-1:0] BLACK_TOL_RESET = 10'd100;
   localparam logic [TOL_WIDTH-1:0] WHITE_TOL_RESET = 10'd400;
   localparam logic [THRESH_WIDTH-1:0] REVERSE_RESET = 11'd307;

   localparam logic [GAIN_WIDTH-1:0] BASE_SHARP = 10'd512;
   localparam logic [GAIN_WIDTH-1:0] INNER_SHARP = 10'd922;
   localparam logic [GAIN_WIDTH-1:0] OUTER_SHARP = 10'd512;
   localparam logic [GAIN_WIDTH-1:0] BASE_MIDDLE = 10'd563;
   localparam logic [GAIN_WIDTH-1:0] INNER_MIDDLE = 10'd819;
   localparam logic [GAIN_WIDTH-1:0] OUTER_MIDDLE = 10'd461;
   localparam logic [GAIN_WIDTH-1:0] BASE_GENTLE = 10'd614;
   localparam logic [GAIN_WIDTH-1:0] INNER_GENTLE = 10'd717;
   localparam logic [GAIN_WIDTH-1:0] OUTER_GENTLE = 10'd410;

   localparam logic signed [11:0] FULL_SCALE = 12'sd1000;
   localparam logic signed [13:0] DRIVE_MAX = 14'sd1024;
   localparam logic signed [13:0] DRIVE_MIN = -14'sd1024;

   typedef struct packed {
      logic [THRESH_WIDTH-1:0] upper_limit;
      logic [THRESH_WIDTH-1:0] mid_limit;
      logic [TOL_WIDTH-1:0]    dark_margin;
      logic [TOL_WIDTH-1:0]    light_margin;
      logic [THRESH_WIDTH-1:0] reverse_speed;
   } cfg_type;

   typedef struct packed {
      logic [SENSOR_COUNT-1:0][SENSOR_WIDTH-1:0] sensor;
      logic signed [POS_WIDTH-1:0]               offset;
   } item_type;

   typedef struct packed {
      logic signed [DRIVE_WIDTH-1:0] left_drive;
      logic signed [DRIVE_WIDTH-1:0] right_drive;
      logic                          reversing;
      logic                          black;
   } drive_type;

endpackage

[hdl/lfdlc_drive.sv]
// Surface classification and saturated motor drive computation for one sensor frame.
module lfdlc_drive
   import lfdlc_pkg::*;
(
   input  cfg_type   cfg,
   input  item_type  item,
   output drive_type result
);

   function automatic logic signed [DRIVE_WIDTH-1:0] sat_drive(input logic signed [13:0] v);
      logic signed [13:0] c;
      begin
         if (v > DRIVE_MAX) begin
            c = DRIVE_MAX;
         end else if (v < DRIVE_MIN) begin
            c = DRIVE_MIN;
         end else begin
            c = v;
         end
         sat_drive = c[DRIVE_WIDTH-1:0];
      end
   endfunction

   logic signed [11:0] black_limit;
   logic [SENSOR_COUNT-1:0] is_black;
   logic [SENSOR_COUNT-1:0] is_white;
   logic all_black;
   logic all_white;

   logic signed [12:0] pos_ext;
   logic sharp;
   logic middle;
   logic negative;
   logic [GAIN_WIDTH-1:0] base;
   logic [GAIN_WIDTH-1:0] inner;
   logic [GAIN_WIDTH-1:0] outer;
   logic [GAIN_WIDTH-1:0] left_gain;
   logic [GAIN_WIDTH-1:0] right_gain;
   logic signed [22:0] left_prod;
   logic signed [22:0] right_prod;
   logic signed [22:0] left_round;
   logic signed [22:0] right_round;
   logic signed [12:0] left_scale;
   logic signed [12:0] right_scale;
   logic signed [13:0] base_ext;
   logic signed [13:0] left_sum;
   logic signed [13:0] right_sum;
   logic signed [13:0] reverse_neg;
   logic signed [DRIVE_WIDTH-1:0] reverse_drive;

   assign black_limit = FULL_SCALE - $signed({2'b00, cfg.dark_margin});

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         is_black[i] = $signed({2'b00, item.sensor[i]}) >= black_limit;
         is_white[i] = item.sensor[i] <= cfg.light_margin;
      end
   end

   assign all_black = &is_black;
   assign all_white = &is_white;

   assign pos_ext = {item.offset[POS_WIDTH-1], item.offset};
   assign sharp = pos_ext > $signed({2'b00, cfg.upper_limit});
   assign middle = pos_ext > $signed({2'b00, cfg.mid_limit});
   assign negative = item.offset[POS_WIDTH-1];

   always_comb begin
      if (sharp) begin
         base = BASE_SHARP;
         inner = INNER_SHARP;
         outer = OUTER_SHARP;
      end else if (middle) begin
         base = BASE_MIDDLE;
         inner = INNER_MIDDLE;
         outer = OUTER_MIDDLE;
      end else begin
         base = BASE_GENTLE;
         inner = INNER_GENTLE;
         outer = OUTER_GENTLE;
      end
   end

   assign left_gain = negative ? inner : outer;
   assign right_gain = negative ? outer : inner;

   assign left_prod = $signed({1'b0, left_gain}) * item.offset;
   assign right_prod = $signed({1'b0, right_gain}) * item.offset;
   assign left_round = left_prod + 23'sd512;
   assign right_round = right_prod + 23'sd512;
   assign left_scale = left_round[22:10];
   assign right_scale = right_round[22:10];

   assign base_ext = $signed({4'b0000, base});
   assign left_sum = base_ext + {left_scale[12], left_scale};
   assign right_sum = base_ext - {right_scale[12], right_scale};

   assign reverse_neg = -$signed({3'b000, cfg.reverse_speed});
   assign reverse_drive = sat_drive(reverse_neg);

   always_comb begin
      result.black = all_black;
      result.reversing = all_white;
      if (all_white) begin
         result.left_drive = reverse_drive;
         result.right_drive = reverse_drive;
      end else begin
         result.left_drive = sat_drive(left_sum);
         result.right_drive = sat_drive(right_sum);
      end
   end

endmodule

[hdl/line_follow_drive_and_lap_count_top.sv]
// Top level of the line-follow drive and lap counter with stream ports and register port.
//
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/tready    | req_tdata: five sensors, line position
// rsp     | out       | rsp_tvalid/tready    | rsp_tdata: drives, flags, lap total
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// Each transaction passes an input register and a result register,
// and a new transaction can be accepted at a rate of one per cycle while the result is not stalled.
// The lap state advances when a frame moves from the input register to the result register.
// Reset restores register defaults, clears the lap count and marks the surface as black.
// A stalled result holds both registers in turn; the register port is always ready.
module line_follow_drive_and_lap_count_top
   import lfdlc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0: sensor_a, sensor_b, sensor_c, sensor_d, sensor_e, line offset.
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // Fields from bit 0: left_drive, right_drive, reversing, lap_edge, lap_total.
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   item_type item_ff;
   item_type item_in;
   logic     stage_valid_ff;
   logic     stage_valid_in;

   drive_type drive;

   logic                 dark_prev_ff;
   logic                 dark_prev_in;
   logic [LAP_WIDTH-1:0] lap_count_ff;
   logic [LAP_WIDTH-1:0] lap_count_in;
   logic                 edge_hit;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [DRIVE_WIDTH-1:0] left_ff;
   logic signed [DRIVE_WIDTH-1:0] left_in;
   logic signed [DRIVE_WIDTH-1:0] right_ff;
   logic signed [DRIVE_WIDTH-1:0] right_in;
   logic                         reversing_ff;
   logic                         reversing_in;
   logic                         lap_edge_ff;
   logic                         lap_edge_in;
   logic [LAP_TOTAL_WIDTH-1:0]   lap_total_ff;
   logic [LAP_TOTAL_WIDTH-1:0]   lap_total_in;

   logic out_free;
   logic advance;
   logic req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_UPPER_LIMIT:   cfg_in.upper_limit = csr_wdata;
            REG_MID_LIMIT:     cfg_in.mid_limit = csr_wdata;
            REG_DARK_MARGIN:   cfg_in.dark_margin = csr_wdata[TOL_WIDTH-1:0];
            REG_LIGHT_MARGIN:  cfg_in.light_margin = csr_wdata[TOL_WIDTH-1:0];
            REG_REVERSE_SPEED: cfg_in.reverse_speed = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance = stage_valid_ff && out_free;
   assign req_tready = !stage_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         item_in.sensor[i] = req_tdata[i*SENSOR_WIDTH +: SENSOR_WIDTH];
      end
      item_in.offset = req_tdata[SENSOR_COUNT*SENSOR_WIDTH +: POS_WIDTH];
      stage_valid_in = req_take || (stage_valid_ff && !advance);
   end

   lfdlc_drive drive_unit (
      .cfg    (cfg_ff),
      .item   (item_ff),
      .result (drive)
   );

   assign edge_hit = drive.black && !dark_prev_ff;

   always_comb begin
      dark_prev_in = dark_prev_ff;
      lap_count_in = lap_count_ff;
      if (advance) begin
         dark_prev_in = drive.black;
         if (edge_hit) begin
            lap_count_in = lap_count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      left_in = left_ff;
      right_in = right_ff;
      reversing_in = reversing_ff;
      lap_edge_in = lap_edge_ff;
      lap_total_in = lap_total_ff;
      if (advance) begin
         left_in = drive.left_drive;
         right_in = drive.right_drive;
         reversing_in = drive.reversing;
         lap_edge_in = edge_hit;
         lap_total_in = LAP_TOTAL_WIDTH'(lap_count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_limit <= UPPER_RESET;
         cfg_ff.mid_limit <= MIDDLE_RESET;
         cfg_ff.dark_margin <= BLACK_TOL_RESET;
         cfg_ff.light_margin <= WHITE_TOL_RESET;
         cfg_ff.reverse_speed <= REVERSE_RESET;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dark_prev_ff <= 1'b1;
         lap_count_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dark_prev_ff <= dark_prev_in;
         lap_count_ff <= lap_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      left_ff <= left_in;
      right_ff <= right_in;
      reversing_ff <= reversing_in;
      lap_edge_ff <= lap_edge_in;
      lap_total_ff <= lap_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_WIDTH-RSP_FIELD_BITS){1'b0}}, lap_total_ff, lap_edge_ff,
                       reversing_ff, right_ff, left_ff};

endmodule
